>>> rtl/assert_macros.svh
// Assertion macros used by the cross gesture detector top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Check a property on every clock edge outside reset.
`define CGD_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Check a property on every clock edge, reset included.
`define CGD_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) (prop)) else $error(msg);
`endif

>>> rtl/cgd_pkg.sv
// Shared types and constants of the cross gesture detector.
package cgd_pkg;
    localparam int COORD_BITS = 12;
    localparam int CNT_BITS = 4;
    localparam int LEN_BITS = 25;
    localparam int THR_BITS = 12;
    localparam int LIM_BITS = 8;
    localparam int ADDR_BITS = 4;

    localparam logic [LEN_BITS-1:0] MIN_LENGTH_SQ_RST = 25'd10000;
    localparam logic [THR_BITS-1:0] MOVE_THRESHOLD_RST = 12'd10;
    localparam logic [THR_BITS-1:0] SLOPE_LIMIT_RST = 12'd2;
    localparam logic [LIM_BITS-1:0] RESTART_LIMIT_RST = 8'd5;

    localparam logic [ADDR_BITS-1:0] ADDR_MIN_LENGTH_SQ = 4'h0;
    localparam logic [ADDR_BITS-1:0] ADDR_MOVE_THRESHOLD = 4'h4;
    localparam logic [ADDR_BITS-1:0] ADDR_SLOPE_LIMIT = 4'h8;
    localparam logic [ADDR_BITS-1:0] ADDR_RESTART_LIMIT = 4'hC;

    // Width of a signed coordinate difference.
    localparam int DIFF_BITS = COORD_BITS + 1;
    // Width of a signed product or a cross product.
    localparam int PROD_BITS = 2 * DIFF_BITS + 1;

    typedef struct packed {
        logic [CNT_BITS-1:0]   touch_count;
        logic [COORD_BITS-1:0] pos_x;
        logic [COORD_BITS-1:0] pos_y;
    } in_word_t;

    typedef struct packed {
        logic       cross_detected;
        logic [1:0] strokes_held;
    } out_word_t;

    // Divider request and answer.
    typedef struct packed {
        logic                        start;
        logic signed [DIFF_BITS-1:0] num;
        logic signed [DIFF_BITS-1:0] den;
    } div_req_t;

    typedef struct packed {
        logic                        done;
        logic signed [DIFF_BITS-1:0] quo;
    } div_rsp_t;
endpackage

>>> rtl/cgd_divider.sv
// Serial signed divider, quotient truncated toward zero, one bit a cycle.
module cgd_divider (
    input  logic              clk,
    input  logic              rst_n,
    input  cgd_pkg::div_req_t req,
    output cgd_pkg::div_rsp_t rsp
);
    localparam int W = cgd_pkg::DIFF_BITS;

    typedef enum logic [1:0] {IDLE, RUN, FIN} div_state_t;

    div_state_t       state_reg;
    logic [W-1:0]     quo_reg;
    logic [W-1:0]     rem_reg;
    logic [W-1:0]     den_reg;
    logic [$clog2(W+1)-1:0] cnt_reg;
    logic             neg_reg;
    logic [W-1:0]     num_abs;
    logic [W-1:0]     den_abs;
    logic [W:0]       trial;
    logic [W-1:0]     rem_shift;

    assign num_abs = req.num[W-1] ? W'(-req.num) : W'(req.num);
    assign den_abs = req.den[W-1] ? W'(-req.den) : W'(req.den);
    assign rem_shift = {rem_reg[W-2:0], quo_reg[W-1]};
    assign trial = {1'b0, rem_shift} - {1'b0, den_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= IDLE;
            cnt_reg   <= '0;
            quo_reg   <= '0;
            rem_reg   <= '0;
            den_reg   <= '0;
            neg_reg   <= 1'b0;
            rsp.done  <= 1'b0;
            rsp.quo   <= '0;
        end
        else
        begin
            rsp.done <= (state_reg == FIN);
            unique case (state_reg)
                IDLE:
                begin
                    if (req.start)
                    begin
                        quo_reg   <= num_abs;
                        rem_reg   <= '0;
                        den_reg   <= den_abs;
                        neg_reg   <= req.num[W-1] ^ req.den[W-1];
                        cnt_reg   <= '0;
                        state_reg <= RUN;
                    end
                end
                RUN:
                begin
                    // shift one dividend bit in, subtract where it fits
                    if (!trial[W])
                    begin
                        rem_reg <= trial[W-1:0];
                        quo_reg <= {quo_reg[W-2:0], 1'b1};
                    end
                    else
                    begin
                        rem_reg <= rem_shift;
                        quo_reg <= {quo_reg[W-2:0], 1'b0};
                    end
                    cnt_reg <= cnt_reg + 1'b1;
                    if (cnt_reg == ($clog2(W+1))'(W - 1))
                    begin
                        state_reg <= FIN;
                    end
                end
                FIN:
                begin
                    rsp.quo   <= neg_reg ? W'(-quo_reg) : quo_reg;
                    state_reg <= IDLE;
                end
                default:
                begin
                    state_reg <= IDLE;
                end
            endcase
        end
    end
endmodule

>>> rtl/cross_gesture_detector.sv
// Top level of the cross gesture detector.
// Takes one touch frame per word and returns one result word per frame. A
// single-touch frame from the third of its stroke on that pushes a moved
// point runs two serial slope divisions on the shared divider; the lift
// frame after the second stroke runs the segment test as twelve products
// through one shared multiplier, one product a cycle, when the bounding
// boxes overlap, and skips the products when they do not. Other frames go
// straight from the frame step to the result step. The input is not ready
// while a frame is being worked; a result that waits in the output register
// holds the next frame in its last step.
`include "assert_macros.svh"
module cross_gesture_detector (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  cgd_pkg::in_word_t                  in_data,
    output logic                               out_valid,
    input  logic                               out_ready,
    output cgd_pkg::out_word_t                 out_data,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [cgd_pkg::ADDR_BITS-1:0]      paddr,
    input  logic [31:0]                        pwdata,
    output logic [31:0]                        prdata,
    output logic                               pready
);
    localparam int CW = cgd_pkg::COORD_BITS;
    localparam int DW = cgd_pkg::DIFF_BITS;
    localparam int PW = cgd_pkg::PROD_BITS;

    typedef enum logic [3:0] {
        S_IDLE, S_FRAME, S_DIV1, S_WAIT1, S_DIV2, S_WAIT2, S_SLOPE,
        S_BOX, S_MUL, S_LEN, S_OUT
    } state_t;

    // configuration
    logic [cgd_pkg::LEN_BITS-1:0] min_length_sq_reg;
    logic [cgd_pkg::THR_BITS-1:0] move_threshold_reg;
    logic [cgd_pkg::THR_BITS-1:0] slope_limit_reg;
    logic [cgd_pkg::LIM_BITS-1:0] restart_limit_reg;

    state_t state_reg;
    logic [1:0] stroke_number_reg;
    logic [1:0] frames_in_stroke_reg;
    logic [7:0] gap_frames_reg;
    logic [CW-1:0] p_reg [8];
    logic [CW-1:0] q_reg [8];
    cgd_pkg::in_word_t in_reg;
    cgd_pkg::out_word_t out_reg;
    logic out_valid_reg;
    logic cross_reg;
    // which line the slope test looks at: 0 first, 1 second
    logic sel_reg;
    logic signed [DW-1:0] s1_reg;
    logic [3:0] step_reg;
    logic signed [PW-1:0] prod_reg;
    logic signed [PW+1:0] acc_reg;
    logic [1:0] sign_a_reg;
    logic [1:0] sign_b_reg;
    logic sgn_fail_reg;

    cgd_pkg::div_req_t div_req;
    cgd_pkg::div_rsp_t div_rsp;

    cgd_divider u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    // APB
    logic cfg_wr;
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_comb
    begin
        prdata = '0;
        unique case (paddr)
            cgd_pkg::ADDR_MIN_LENGTH_SQ:  prdata = 32'(min_length_sq_reg);
            cgd_pkg::ADDR_MOVE_THRESHOLD: prdata = 32'(move_threshold_reg);
            cgd_pkg::ADDR_SLOPE_LIMIT:    prdata = 32'(slope_limit_reg);
            cgd_pkg::ADDR_RESTART_LIMIT:  prdata = 32'(restart_limit_reg);
            default:                      prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_length_sq_reg  <= cgd_pkg::MIN_LENGTH_SQ_RST;
            move_threshold_reg <= cgd_pkg::MOVE_THRESHOLD_RST;
            slope_limit_reg    <= cgd_pkg::SLOPE_LIMIT_RST;
            restart_limit_reg  <= cgd_pkg::RESTART_LIMIT_RST;
        end
        else if (cfg_wr)
        begin
            unique case (paddr)
                cgd_pkg::ADDR_MIN_LENGTH_SQ:
                    min_length_sq_reg <= pwdata[cgd_pkg::LEN_BITS-1:0];
                cgd_pkg::ADDR_MOVE_THRESHOLD:
                    move_threshold_reg <= pwdata[cgd_pkg::THR_BITS-1:0];
                cgd_pkg::ADDR_SLOPE_LIMIT:
                    slope_limit_reg <= pwdata[cgd_pkg::THR_BITS-1:0];
                cgd_pkg::ADDR_RESTART_LIMIT:
                    restart_limit_reg <= pwdata[cgd_pkg::LIM_BITS-1:0];
                default: ;
            endcase
        end
    end

    // result register loads when it is empty or being emptied
    logic out_load;
    assign out_load  = (state_reg == S_OUT) && (!out_valid_reg || out_ready);
    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    // selected line for the frame and slope work
    logic [CW-1:0] l [8];
    always_comb
    begin
        for (int i = 0; i < 8; i++)
        begin
            l[i] = sel_reg ? q_reg[i] : p_reg[i];
        end
    end

    function automatic logic signed [DW-1:0] sdiff(input logic [CW-1:0] a,
                                                   input logic [CW-1:0] b);
        sdiff = $signed({1'b0, a}) - $signed({1'b0, b});
    endfunction

    function automatic logic [DW-1:0] uabs(input logic signed [DW-1:0] v);
        uabs = v[DW-1] ? DW'(-v) : DW'(v);
    endfunction

    logic [1:0] fis_inc;
    logic [1:0] line_idx;
    logic mv;
    assign fis_inc = (frames_in_stroke_reg < 2'd3) ? frames_in_stroke_reg + 2'd1
                                                   : frames_in_stroke_reg;
    always_comb
    begin
        line_idx = 2'd0;
        mv = 1'b0;
        if (stroke_number_reg == 2'd1 || stroke_number_reg == 2'd2)
        begin
            line_idx = stroke_number_reg;
        end
        mv = (uabs(sdiff(in_reg.pos_x, l[6])) > DW'(move_threshold_reg)) &&
             (uabs(sdiff(in_reg.pos_y, l[7])) > DW'(move_threshold_reg));
    end

    // shared multiplier: operands chosen by step
    logic signed [DW:0] ma;
    logic signed [DW:0] mb;
    logic signed [PW+1:0] mprod;
    logic [CW-1:0] ax, ay, bx, by, cx, cy, ex, ey;
    assign ax = p_reg[0];
    assign ay = p_reg[1];
    assign bx = p_reg[6];
    assign by = p_reg[7];
    assign cx = q_reg[0];
    assign cy = q_reg[1];
    assign ex = q_reg[6];
    assign ey = q_reg[7];

    always_comb
    begin
        ma = '0;
        mb = '0;
        unique case (step_reg)
            4'd0: begin ma = (DW+1)'(sdiff(bx, ax)); mb = (DW+1)'(sdiff(cy, ay)); end
            4'd1: begin ma = (DW+1)'(sdiff(by, ay)); mb = (DW+1)'(sdiff(cx, ax)); end
            4'd2: begin ma = (DW+1)'(sdiff(bx, ax)); mb = (DW+1)'(sdiff(ey, ay)); end
            4'd3: begin ma = (DW+1)'(sdiff(by, ay)); mb = (DW+1)'(sdiff(ex, ax)); end
            4'd4: begin ma = (DW+1)'(sdiff(ex, cx)); mb = (DW+1)'(sdiff(ay, cy)); end
            4'd5: begin ma = (DW+1)'(sdiff(ey, cy)); mb = (DW+1)'(sdiff(ax, cx)); end
            4'd6: begin ma = (DW+1)'(sdiff(ex, cx)); mb = (DW+1)'(sdiff(by, cy)); end
            4'd7: begin ma = (DW+1)'(sdiff(ey, cy)); mb = (DW+1)'(sdiff(bx, cx)); end
            4'd8: begin ma = (DW+1)'(sdiff(ax, bx)); mb = ma; end
            4'd9: begin ma = (DW+1)'(sdiff(ay, by)); mb = ma; end
            4'd10: begin ma = (DW+1)'(sdiff(cx, ex)); mb = ma; end
            4'd11: begin ma = (DW+1)'(sdiff(cy, ey)); mb = ma; end
            default: begin ma = '0; mb = '0; end
        endcase
    end
    assign mprod = (PW+2)'(ma * mb);

    // bounding boxes overlap
    function automatic logic [CW-1:0] umax(input logic [CW-1:0] a, input logic [CW-1:0] b);
        umax = (a > b) ? a : b;
    endfunction
    function automatic logic [CW-1:0] umin(input logic [CW-1:0] a, input logic [CW-1:0] b);
        umin = (a < b) ? a : b;
    endfunction
    logic box_ok;
    assign box_ok = !(umax(ax, bx) < umin(cx, ex)) && !(umax(cx, ex) < umin(ax, bx)) &&
                    !(umax(ay, by) < umin(cy, ey)) && !(umax(cy, ey) < umin(ay, by));

    // sign of a cross product: 01 positive, 10 negative, 00 zero
    function automatic logic [1:0] sgn(input logic signed [PW+1:0] v);
        sgn = (v == '0) ? 2'b00 : (v[PW+1] ? 2'b10 : 2'b01);
    endfunction
    function automatic logic same_side(input logic [1:0] a, input logic [1:0] b);
        same_side = (a != 2'b00) && (a == b);
    endfunction

    logic signed [DW:0] sdiff_s;
    logic [DW:0] sabs;
    assign sdiff_s = (DW+1)'(div_rsp.quo) - (DW+1)'(s1_reg);
    assign sabs = sdiff_s[DW] ? (DW+1)'(-sdiff_s) : (DW+1)'(sdiff_s);

    always_comb
    begin
        div_req.start = (state_reg == S_DIV1) || (state_reg == S_DIV2);
        div_req.num = '0;
        div_req.den = '0;
        if (state_reg == S_DIV1)
        begin
            div_req.num = sdiff(l[5], l[3]);
            div_req.den = sdiff(l[4], l[2]);
        end
        else
        begin
            div_req.num = sdiff(l[7], l[5]);
            div_req.den = sdiff(l[6], l[4]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg            <= S_IDLE;
            stroke_number_reg    <= 2'd0;
            frames_in_stroke_reg <= 2'd0;
            gap_frames_reg       <= 8'd0;
            out_valid_reg        <= 1'b0;
            out_reg              <= '0;
            in_reg               <= '0;
            sel_reg              <= 1'b0;
            step_reg             <= 4'd0;
            cross_reg            <= 1'b0;
            s1_reg               <= '0;
            prod_reg             <= '0;
            acc_reg              <= '0;
            sign_a_reg           <= 2'b00;
            sign_b_reg           <= 2'b00;
            sgn_fail_reg         <= 1'b0;
            for (int i = 0; i < 8; i++)
            begin
                p_reg[i] <= '0;
                q_reg[i] <= '0;
            end
        end
        else
        begin
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_valid && in_ready)
                    begin
                        in_reg    <= in_data;
                        cross_reg <= 1'b0;
                        sel_reg   <= (stroke_number_reg == 2'd2);
                        state_reg <= S_FRAME;
                    end
                end
                S_FRAME:
                begin
                    if (in_reg.touch_count != 4'd1)
                    begin
                        frames_in_stroke_reg <= 2'd0;
                        if (gap_frames_reg != 8'd255)
                        begin
                            gap_frames_reg <= gap_frames_reg + 8'd1;
                        end
                        if (stroke_number_reg == 2'd2)
                        begin
                            step_reg     <= 4'd0;
                            sgn_fail_reg <= 1'b0;
                            state_reg    <= S_BOX;
                        end
                        else
                        begin
                            state_reg <= S_OUT;
                            if (((gap_frames_reg == 8'd255) ? gap_frames_reg
                                 : gap_frames_reg + 8'd1) >= restart_limit_reg)
                            begin
                                stroke_number_reg <= 2'd0;
                            end
                        end
                    end
                    else
                    begin
                        gap_frames_reg       <= 8'd0;
                        frames_in_stroke_reg <= fis_inc;
                        if (fis_inc == 2'd1)
                        begin
                            state_reg <= S_OUT;
                            // open a new stroke
                            if (stroke_number_reg == 2'd0)
                            begin
                                stroke_number_reg <= 2'd1;
                                for (int i = 0; i < 8; i += 2)
                                begin
                                    p_reg[i]   <= in_reg.pos_x;
                                    p_reg[i+1] <= in_reg.pos_y;
                                end
                            end
                            else
                            begin
                                stroke_number_reg <= 2'd2;
                                for (int i = 0; i < 8; i += 2)
                                begin
                                    q_reg[i]   <= in_reg.pos_x;
                                    q_reg[i+1] <= in_reg.pos_y;
                                end
                            end
                        end
                        else if (line_idx != 2'd0 && (fis_inc == 2'd2 || mv))
                        begin
                            if (line_idx == 2'd1)
                            begin
                                p_reg[2] <= p_reg[4]; p_reg[3] <= p_reg[5];
                                p_reg[4] <= p_reg[6]; p_reg[5] <= p_reg[7];
                                p_reg[6] <= in_reg.pos_x; p_reg[7] <= in_reg.pos_y;
                            end
                            else
                            begin
                                q_reg[2] <= q_reg[4]; q_reg[3] <= q_reg[5];
                                q_reg[4] <= q_reg[6]; q_reg[5] <= q_reg[7];
                                q_reg[6] <= in_reg.pos_x; q_reg[7] <= in_reg.pos_y;
                            end
                            state_reg <= (fis_inc == 2'd3) ? S_DIV1 : S_OUT;
                        end
                        else
                        begin
                            state_reg <= S_OUT;
                        end
                    end
                end
                S_DIV1:
                begin
                    state_reg <= S_WAIT1;
                end
                S_WAIT1:
                begin
                    if (div_rsp.done)
                    begin
                        s1_reg    <= div_rsp.quo;
                        state_reg <= S_DIV2;
                    end
                end
                S_DIV2:
                begin
                    state_reg <= S_WAIT2;
                end
                S_WAIT2:
                begin
                    if (div_rsp.done)
                    begin
                        state_reg <= S_OUT;
                        // vertical steps pass; otherwise compare slopes
                        if (l[6] != l[4] && l[4] != l[2] &&
                            sabs > (DW+1)'(slope_limit_reg))
                        begin
                            stroke_number_reg <= 2'd0;
                            for (int i = 0; i < 8; i++)
                            begin
                                p_reg[i] <= '0;
                                q_reg[i] <= '0;
                            end
                        end
                    end
                end
                S_BOX:
                begin
                    step_reg  <= 4'd0;
                    state_reg <= box_ok ? S_MUL : S_LEN;
                    cross_reg <= 1'b0;
                    sgn_fail_reg <= !box_ok;
                end
                S_MUL:
                begin
                    // odd steps close a cross product or a squared length
                    step_reg <= step_reg + 4'd1;
                    if (!step_reg[0])
                    begin
                        prod_reg <= PW'(mprod);
                    end
                    else
                    begin
                        unique case (step_reg)
                            4'd1: sign_a_reg <= sgn((PW+2)'(prod_reg) - mprod);
                            4'd3:
                            begin
                                if (same_side(sign_a_reg, sgn((PW+2)'(prod_reg) - mprod)))
                                begin
                                    sgn_fail_reg <= 1'b1;
                                end
                            end
                            4'd5: sign_b_reg <= sgn((PW+2)'(prod_reg) - mprod);
                            4'd7:
                            begin
                                if (same_side(sign_b_reg, sgn((PW+2)'(prod_reg) - mprod)))
                                begin
                                    sgn_fail_reg <= 1'b1;
                                end
                            end
                            4'd9:
                            begin
                                acc_reg <= (PW+2)'(prod_reg) + mprod;
                            end
                            4'd11:
                            begin
                                // both lengths must exceed the threshold
                                if (!(acc_reg > (PW+2)'(min_length_sq_reg)) ||
                                    !(((PW+2)'(prod_reg) + mprod) >
                                      (PW+2)'(min_length_sq_reg)))
                                begin
                                    sgn_fail_reg <= 1'b1;
                                end
                                state_reg <= S_LEN;
                            end
                            default: ;
                        endcase
                    end
                end
                S_LEN:
                begin
                    if (!sgn_fail_reg)
                    begin
                        cross_reg <= 1'b1;
                        for (int i = 0; i < 8; i++)
                        begin
                            p_reg[i] <= '0;
                            q_reg[i] <= '0;
                        end
                    end
                    stroke_number_reg <= 2'd0;
                    state_reg <= S_OUT;
                end
                S_OUT:
                begin
                    // hold until the result register frees
                    if (out_load)
                    begin
                        out_reg.cross_detected <= cross_reg;
                        out_reg.strokes_held   <= stroke_number_reg;
                        state_reg              <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    `CGD_ASSERT(a_strokes_range, clk, rst_n, stroke_number_reg != 2'd3,
                "stroke count out of range")
    `CGD_ASSERT(a_cross_clears, clk, rst_n,
                (out_valid_reg && out_reg.cross_detected) |-> out_reg.strokes_held == 2'd0,
                "cross reported with strokes held")
    `CGD_ASSERT(a_no_accept_busy, clk, rst_n,
                (state_reg != S_IDLE) |-> !in_ready, "input taken while busy")
endmodule
